FILE: rtl/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Item types, fixed point constants and the byte clamp shared by the
// 4:2:0 block to RGB converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_top_left;
    logic [7:0] green_top_left;
    logic [7:0] blue_top_left;
    logic [7:0] red_top_right;
    logic [7:0] green_top_right;
    logic [7:0] blue_top_right;
    logic [7:0] red_bottom_left;
    logic [7:0] green_bottom_left;
    logic [7:0] blue_bottom_left;
    logic [7:0] red_bottom_right;
    logic [7:0] green_bottom_right;
    logic [7:0] blue_bottom_right;
  } out_item_t;

  localparam int FRAC  = 16;
  localparam int SUM_W = 28;
  localparam int D_W   = 25;
  localparam int IDX_W = 10;
  localparam int X_W   = 20;

  localparam longint K_Y  = 76284;
  localparam longint K_RV = 104595;
  localparam longint K_BU = 132252;
  localparam longint K_GV = 53281;
  localparam longint K_GU = 25625;

  localparam longint G_LEVELS = 1023;
  localparam longint C_OFS    = 128 * (K_GV + K_GU);
  localparam longint C_RANGE  = 255 * (K_GV + K_GU);

  // index estimate: d * 1023 / range as a reciprocal product
  localparam int     S1   = 40;
  localparam int     M1_W = 26;
  localparam longint M1   = (G_LEVELS << S1) / C_RANGE;
  localparam int     P1_W = D_W + M1_W;
  localparam int     DK_W = D_W + IDX_W;

  // dequantize: idx * range / 1023 = idx * DQ_HI + idx * DQ_LO / 1023
  localparam longint DQ_HI = C_RANGE / G_LEVELS;
  localparam longint DQ_LO = C_RANGE % G_LEVELS;
  localparam int     S3    = 30;
  localparam int     M3_W  = 21;
  localparam longint M3    = (longint'(1) << S3) / G_LEVELS;
  localparam int     P3_W  = X_W + M3_W;

  localparam int Q_LAT = 7;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(255 << FRAC);

  function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] v);
    logic [7:0] res;
    if (v[SUM_W-1] || (v == SUM_W'(0))) begin
      res = 8'd0;
    end else if (v >= SAT_MAX) begin
      res = 8'hFF;
    end else begin
      res = v[FRAC+7:FRAC];
    end
    return res;
  endfunction

endpackage

FILE: rtl/yuv420_block_to_rgb.sv
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb
// BT.601 conversion of one 2x2 block of a 4:2:0 frame to four RGB pixels.
// Pipeline: 9 stages, from the input registers through the valid line to the output register.
// Throughput: one item per cycle; busy is tied low.
// Results are strobed for one cycle; the receiver cannot stall the pipe.
// Reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  y2r_pkg::in_item_t    in_data,
  output logic                 out_valid,
  output y2r_pkg::out_item_t   out_data
);

  localparam int SUM_W = y2r_pkg::SUM_W;
  localparam int D_W   = y2r_pkg::D_W;
  localparam int Q_LAT = y2r_pkg::Q_LAT;

  localparam logic signed [SUM_W-1:0] KY  = SUM_W'(y2r_pkg::K_Y);
  localparam logic signed [SUM_W-1:0] KRV = SUM_W'(y2r_pkg::K_RV);
  localparam logic signed [SUM_W-1:0] KBU = SUM_W'(y2r_pkg::K_BU);
  localparam logic signed [SUM_W-1:0] KGV = SUM_W'(y2r_pkg::K_GV);
  localparam logic signed [SUM_W-1:0] KGU = SUM_W'(y2r_pkg::K_GU);
  localparam logic signed [SUM_W-1:0] COFS = SUM_W'(y2r_pkg::C_OFS);
  localparam logic signed [SUM_W-1:0] OFS_Y = SUM_W'(16);
  localparam logic signed [SUM_W-1:0] OFS_C = SUM_W'(128);

  typedef struct packed {
    logic [3:0][SUM_W-1:0] ys;
    logic [SUM_W-1:0]      rs;
    logic [SUM_W-1:0]      bs;
  } carry_t;

  logic                     accept;
  logic [3:0][7:0]          luma;
  logic signed [SUM_W-1:0]  uc;
  logic signed [SUM_W-1:0]  vc;
  logic signed [SUM_W-1:0]  dsum;
  carry_t                   car_nxt;

  logic                     v1_r;
  carry_t                   car1_r;
  logic [D_W-1:0]           d1_r;
  logic [D_W-1:0]           deq;
  carry_t                   line_r [Q_LAT];
  logic [Q_LAT-1:0]         vline_r;

  logic [3:0][7:0]          red;
  logic [3:0][7:0]          green;
  logic [3:0][7:0]          blue;
  y2r_pkg::out_item_t       out_nxt;
  y2r_pkg::out_item_t       out_data_r;
  logic                     out_valid_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign luma[0] = in_data.luma_top_left;
  assign luma[1] = in_data.luma_top_right;
  assign luma[2] = in_data.luma_bottom_left;
  assign luma[3] = in_data.luma_bottom_right;

  always_comb begin
    uc = $signed({{(SUM_W-8){1'b0}}, in_data.chroma_blue}) - OFS_C;
    vc = $signed({{(SUM_W-8){1'b0}}, in_data.chroma_red}) - OFS_C;
    for (int i = 0; i < 4; i++) begin
      car_nxt.ys[i] = ($signed({{(SUM_W-8){1'b0}}, luma[i]}) - OFS_Y) * KY;
    end
    car_nxt.rs = vc * KRV;
    car_nxt.bs = uc * KBU;
    dsum = vc * KGV + uc * KGU + COFS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      vline_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      vline_r     <= {vline_r[Q_LAT-2:0], v1_r};
      out_valid_r <= vline_r[Q_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    car1_r    <= car_nxt;
    d1_r      <= dsum[D_W-1:0];
    line_r[0] <= car1_r;
    for (int k = 1; k < Q_LAT; k++) begin
      line_r[k] <= line_r[k-1];
    end
    out_data_r <= out_nxt;
  end

  y2r_green_quant u_quant (
    .clk (clk),
    .d   (d1_r),
    .deq (deq)
  );

  always_comb begin
    logic signed [SUM_W-1:0] ysv;
    logic signed [SUM_W-1:0] deqv;
    deqv = $signed({{(SUM_W-D_W){1'b0}}, deq});
    for (int i = 0; i < 4; i++) begin
      ysv      = $signed(line_r[Q_LAT-1].ys[i]);
      red[i]   = y2r_pkg::clamp_byte(ysv + $signed(line_r[Q_LAT-1].rs));
      blue[i]  = y2r_pkg::clamp_byte(ysv + $signed(line_r[Q_LAT-1].bs));
      green[i] = y2r_pkg::clamp_byte(ysv + COFS - deqv);
    end
    out_nxt.red_top_left       = red[0];
    out_nxt.green_top_left     = green[0];
    out_nxt.blue_top_left      = blue[0];
    out_nxt.red_top_right      = red[1];
    out_nxt.green_top_right    = green[1];
    out_nxt.blue_top_right     = blue[1];
    out_nxt.red_bottom_left    = red[2];
    out_nxt.green_bottom_left  = green[2];
    out_nxt.blue_bottom_left   = blue[2];
    out_nxt.red_bottom_right   = red[3];
    out_nxt.green_bottom_right = green[3];
    out_nxt.blue_bottom_right  = blue[3];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/y2r_green_quant.sv
// ----------------------------------------------------------------------------
// y2r_green_quant
// Quantizes the offset green chroma term to a 10-bit index and maps the
// index back to its dequantized offset value, over seven register stages.
// ----------------------------------------------------------------------------
module y2r_green_quant (
  input  logic                    clk,
  input  logic [y2r_pkg::D_W-1:0] d,
  output logic [y2r_pkg::D_W-1:0] deq
);

  localparam int D_W   = y2r_pkg::D_W;
  localparam int IDX_W = y2r_pkg::IDX_W;
  localparam int X_W   = y2r_pkg::X_W;
  localparam int P1_W  = y2r_pkg::P1_W;
  localparam int DK_W  = y2r_pkg::DK_W;
  localparam int P3_W  = y2r_pkg::P3_W;
  localparam int S1    = y2r_pkg::S1;
  localparam int S3    = y2r_pkg::S3;

  logic [P1_W-1:0]  pd_r;
  logic [D_W-1:0]   d1_r;
  logic [IDX_W-1:0] est1_r;
  logic [DK_W-1:0]  er_r;
  logic [DK_W-1:0]  dk_r;
  logic [IDX_W-1:0] idx_r;
  logic [X_W-1:0]   xl_r;
  logic [D_W-1:0]   xh_r;
  logic [P3_W-1:0]  p3_r;
  logic [X_W-1:0]   xl5_r;
  logic [D_W-1:0]   xh5_r;
  logic [IDX_W-1:0] est2_r;
  logic [X_W-1:0]   e2k_r;
  logic [X_W-1:0]   xl6_r;
  logic [D_W-1:0]   xh6_r;
  logic [D_W-1:0]   deq_r;

  logic [IDX_W-1:0] est1_nxt;
  logic [IDX_W-1:0] est2_nxt;

  assign est1_nxt = pd_r[S1 +: IDX_W];
  assign est2_nxt = p3_r[S3 +: IDX_W];

  always_ff @(posedge clk) begin
    pd_r   <= P1_W'(d) * P1_W'(y2r_pkg::M1);
    d1_r   <= d;

    est1_r <= est1_nxt;
    er_r   <= DK_W'(est1_nxt) * DK_W'(y2r_pkg::C_RANGE);
    dk_r   <= (DK_W'(d1_r) << IDX_W) - DK_W'(d1_r);

    idx_r  <= est1_r + IDX_W'(dk_r >= (er_r + DK_W'(y2r_pkg::C_RANGE)));

    xl_r   <= X_W'(idx_r) * X_W'(y2r_pkg::DQ_LO);
    xh_r   <= D_W'(idx_r) * D_W'(y2r_pkg::DQ_HI);

    p3_r   <= P3_W'(xl_r) * P3_W'(y2r_pkg::M3);
    xl5_r  <= xl_r;
    xh5_r  <= xh_r;

    est2_r <= est2_nxt;
    e2k_r  <= (X_W'(est2_nxt) << IDX_W) - X_W'(est2_nxt);
    xl6_r  <= xl5_r;
    xh6_r  <= xh5_r;

    deq_r  <= xh6_r + D_W'(est2_r)
              + D_W'((xl6_r - e2k_r) >= X_W'(y2r_pkg::G_LEVELS));
  end

  assign deq = deq_r;

endmodule

FILE: rtl/y2r_checker.sv
// ----------------------------------------------------------------------------
// y2r_checker
// Port level checks of the block converter: fixed latency, no refusal of
// items, and equal red and blue for neutral chroma.
// ----------------------------------------------------------------------------
module y2r_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input y2r_pkg::in_item_t  in_data,
  input logic               out_valid,
  input y2r_pkg::out_item_t out_data
);

  localparam int LAT = y2r_pkg::Q_LAT + 2;

  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted item gave no result");

  a_out_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without accepted item");

  a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_data.chroma_blue == 8'd128 && in_data.chroma_red == 8'd128, LAT))
    |-> (out_data.red_top_left == out_data.blue_top_left
         && out_data.red_top_right == out_data.blue_top_right
         && out_data.red_bottom_left == out_data.blue_bottom_left
         && out_data.red_bottom_right == out_data.blue_bottom_right))
    else $error("red and blue differ for neutral chroma");

endmodule

bind yuv420_block_to_rgb y2r_checker u_y2r_checker (.*);
